// File: hw/rtl/sdph_pkg.sv
// Shared widths, reset values and register codes for the spectrum peak-hold block.
package sdph_pkg;

  localparam int BIN_W    = 9;
  localparam int MAG_W    = 32;
  localparam int FRESH_W  = 20;
  localparam int FALL_W   = 20;
  localparam int LVL_W    = 16;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 1;

  localparam int NUM_BINS_DEF = 512;

  // Leading-one position, log2 in Q6.8 and its dB product.
  localparam int POS_W  = 5;
  localparam int LG_W   = 14;
  localparam int PROD_W = 25;
  localparam int DB_W   = PROD_W - 8;
  localparam int FPROD_W = FRESH_W + FALL_W;

  localparam logic signed [11:0]      DB_PER_LOG2 = 12'sd1541;
  localparam logic [FALL_W-1:0]       FALL_RESET  = 20'd15219;
  localparam logic signed [LVL_W-1:0] FLOOR_RESET = -16'sd21504;

  localparam int OFIFO_DEPTH = 4;
  localparam int OPTR_W      = 2;
  localparam int OCNT_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FALL_PER_SAMPLE = 1'b0,
    CFG_FLOOR_LEVEL     = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [BIN_W-1:0]        bin;
    logic signed [LVL_W-1:0] level;
  } res_t;

endpackage

// File: hw/rtl/spectrum_db_peak_hold_decay.sv
// Top level of the per-bin dB peak-hold with decay.
//
//   Port group  Direction  Handshake           Beat contents
//   cfg_        in         cfg_we              cfg_index, cfg_data
//   in_         in         in_valid/in_ready   in_bin_index, in_magnitude, in_fresh_count
//   out_        out        out_valid/out_ready out_bin, out_level
//
// The block takes one beat per cycle while in_ready is high, and each result passes
// stage A, stage B and the result queue. The level memory is read once and written once
// per cycle, and the write of each bin is forwarded to a following beat of the same bin,
// which sets that rate. After reset a clearing pass writes the reset floor into every
// entry, and in_ready stays low until it is done. A stalled output fills a four-entry
// result queue; in_ready drops when that queue and both pipeline stages hold four beats.
module spectrum_db_peak_hold_decay
  import sdph_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [BIN_W-1:0]         in_bin_index,
  input  logic [MAG_W-1:0]         in_magnitude,
  input  logic [FRESH_W-1:0]       in_fresh_count,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [BIN_W-1:0]         out_bin,
  output logic signed [LVL_W-1:0]  out_level
);

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  // Configuration registers.
  logic [FALL_W-1:0]        fall_per_sample_r;
  logic signed [LVL_W-1:0]  floor_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fall_per_sample_r <= FALL_RESET;
      floor_level_r     <= FLOOR_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FALL_PER_SAMPLE: fall_per_sample_r <= cfg_data[FALL_W-1:0];
        CFG_FLOOR_LEVEL:     floor_level_r     <= signed'(cfg_data[LVL_W-1:0]);
        default:             ;
      endcase
    end
  end

  // Clearing pass after reset.
  logic          clr_active_r;
  logic [AW-1:0] clr_cnt_r;
  logic          clr_last;

  assign clr_last = (32'(clr_cnt_r) == NUM_BINS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_last) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // Credit toward the result queue.
  logic              a_v_r;
  logic              b_v_r;
  logic [OCNT_W-1:0] ocnt_r;
  logic [OCNT_W-1:0] inflight;
  logic              in_acc;

  assign inflight = OCNT_W'(a_v_r) + OCNT_W'(b_v_r) + ocnt_r;
  assign in_ready = !clr_active_r && (inflight < OCNT_W'(OFIFO_DEPTH));
  assign in_acc   = in_valid && in_ready;

  // Stage A: accepted beat, memory read in flight.
  logic [BIN_W-1:0]   a_bin_r;
  logic [MAG_W-1:0]   a_mag_r;
  logic [FRESH_W-1:0] a_fresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    a_bin_r   <= in_bin_index;
    a_mag_r   <= in_magnitude;
    a_fresh_r <= in_fresh_count;
  end

  // Level memory with write-first read so a write on the read edge is seen.
  logic signed [LVL_W-1:0] mem [NUM_BINS];
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic signed [LVL_W-1:0] mem_wd;
  logic [AW-1:0]           mem_ra;
  logic signed [LVL_W-1:0] rd_r;

  assign mem_ra = AW'(in_bin_index);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_we && (mem_wa == mem_ra)) begin
      rd_r <= mem_wd;
    end else begin
      rd_r <= mem[mem_ra];
    end
  end

  // Stage A work: dB product and the decay amount.
  logic signed [PROD_W-1:0] b_prod_r;
  logic                     b_tiny_r;
  logic [FPROD_W-1:0]       fall_prod;
  logic [LVL_W-1:0]         fall_sat;

  sdph_db_conv u_db_conv (
    .clk    (clk),
    .mag    (a_mag_r),
    .prod_r (b_prod_r),
    .tiny_r (b_tiny_r)
  );

  assign fall_prod = FPROD_W'(a_fresh_r) * FPROD_W'(fall_per_sample_r);
  assign fall_sat  = (|fall_prod[FPROD_W-1:32]) ? {LVL_W{1'b1}} : fall_prod[31:16];

  // Stage B: level update and memory write.
  logic [BIN_W-1:0]        b_bin_r;
  logic                    b_ok_r;
  logic                    b_fresh_nz_r;
  logic [LVL_W-1:0]        b_fall_r;
  logic signed [LVL_W-1:0] b_cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    b_bin_r      <= a_bin_r;
    b_ok_r       <= (32'(a_bin_r) < NUM_BINS);
    b_fresh_nz_r <= |a_fresh_r;
    b_fall_r     <= fall_sat;
    b_cur_r      <= rd_r;
  end

  // The write made on the edge that moved this beat into stage B missed its read.
  logic                    lw_v_r;
  logic [AW-1:0]           lw_addr_r;
  logic signed [LVL_W-1:0] lw_data_r;

  logic signed [DB_W-1:0]  db_raw;
  logic signed [DB_W-1:0]  floor_ext;
  logic signed [LVL_W-1:0] db_lvl;
  logic signed [LVL_W-1:0] cur;
  logic signed [LVL_W+1:0] dec;
  logic signed [LVL_W-1:0] decayed;
  logic signed [LVL_W-1:0] new_lvl;
  logic signed [LVL_W-1:0] res_lvl;
  logic [AW-1:0]           b_addr;
  logic                    b_we;

  assign b_addr    = AW'(b_bin_r);
  assign db_raw    = signed'(b_prod_r[PROD_W-1:8]);
  assign floor_ext = DB_W'(floor_level_r);
  assign db_lvl    = (b_tiny_r || (db_raw < floor_ext)) ? floor_level_r
                                                          : db_raw[LVL_W-1:0];
  assign cur       = (lw_v_r && (lw_addr_r == b_addr)) ? lw_data_r : b_cur_r;
  assign dec       = (LVL_W+2)'(cur) - signed'({2'b00, b_fall_r});
  assign decayed   = (dec < (LVL_W+2)'(db_lvl)) ? db_lvl : dec[LVL_W-1:0];
  assign new_lvl   = (db_lvl >= cur) ? db_lvl : decayed;
  assign b_we      = b_v_r && b_ok_r && b_fresh_nz_r;

  always_comb begin
    if (!b_ok_r) begin
      res_lvl = floor_level_r;
    end else if (!b_fresh_nz_r) begin
      res_lvl = cur;
    end else begin
      res_lvl = new_lvl;
    end
  end

  assign mem_we = clr_active_r || b_we;
  assign mem_wa = clr_active_r ? clr_cnt_r : b_addr;
  assign mem_wd = clr_active_r ? FLOOR_RESET : new_lvl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_v_r <= 1'b0;
    end else begin
      lw_v_r <= b_we;
    end
  end

  always_ff @(posedge clk) begin
    lw_addr_r <= b_addr;
    lw_data_r <= new_lvl;
  end

  // Result queue.
  res_t              ofifo [OFIFO_DEPTH];
  logic [OPTR_W-1:0] owr_r;
  logic [OPTR_W-1:0] ord_r;
  logic              opush;
  logic              opop;

  assign opush     = b_v_r;
  assign out_valid = (ocnt_r != '0);
  assign opop      = out_valid && out_ready;
  assign out_bin   = ofifo[ord_r].bin;
  assign out_level = ofifo[ord_r].level;

  always_ff @(posedge clk) begin
    if (opush) begin
      ofifo[owr_r] <= '{bin: b_bin_r, level: res_lvl};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (opush) begin
        owr_r <= owr_r + OPTR_W'(1);
      end
      if (opop) begin
        ord_r <= ord_r + OPTR_W'(1);
      end
      ocnt_r <= ocnt_r + OCNT_W'(opush) - OCNT_W'(opop);
    end
  end

endmodule

// File: hw/rtl/sdph_db_conv.sv
// Magnitude to dB conversion: leading-one log2 with linear fraction, registered product.
module sdph_db_conv
  import sdph_pkg::*;
(
  input  logic                       clk,
  input  logic [MAG_W-1:0]           mag,
  output logic signed [PROD_W-1:0]   prod_r,
  output logic                       tiny_r
);

  logic [POS_W-1:0]         pos;
  logic [MAG_W+7:0]         shifted;
  logic [7:0]               frac;
  logic signed [5:0]        expo;
  logic signed [LG_W-1:0]   lg;
  logic signed [PROD_W-1:0] prod_nxt;
  logic                     tiny_nxt;

  // Highest set bit wins.
  always_comb begin
    pos = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mag[i]) begin
        pos = POS_W'(i);
      end
    end
  end

  // The eight bits just below the leading one, zero filled when it sits low.
  assign shifted  = {mag, 8'h00} >> pos;
  assign frac     = shifted[7:0];
  assign expo     = signed'({1'b0, pos}) - 6'sd24;
  assign lg       = signed'({expo, frac});
  assign prod_nxt = PROD_W'(lg) * PROD_W'(DB_PER_LOG2);
  assign tiny_nxt = ~|mag[MAG_W-1:1];

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    tiny_r <= tiny_nxt;
  end

endmodule

// File: tb/tb.sv
// Self-checking testbench for the per-bin dB peak-hold with decay.
`timescale 1ns / 1ps

module tb;
  import sdph_pkg::*;

  // A run that accepts no beat on either channel for this many cycles is hung.
  // The longest legal quiet stretch is the clearing pass after reset
  // or a long run of receiver stalls, both far below this.
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES = 8;
  localparam int BEATS_PER_PHASE = 236;
  localparam int PLAN_ROWS = 26;

  // The receiver switches between three behaviors so that stalls land on
  // every stage of the pipeline, with free-running stretches in between.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_CHOPPY,
    RX_CLOGGED
  } rx_mode_t;

  // One row of the directed plan: either a register write or an input beat.
  // A beat may carry a hand-computed level that replaces the predicted one.
  typedef struct packed {
    logic                    is_cfg;
    cfg_idx_t                reg_idx;
    logic [CFG_W-1:0]        reg_data;
    logic [BIN_W-1:0]        bin;
    logic [MAG_W-1:0]        mag;
    logic [FRESH_W-1:0]      fresh;
    logic                    typed;
    logic signed [LVL_W-1:0] typed_level;
  } plan_row_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  cfg_idx_t                cfg_index = CFG_FALL_PER_SAMPLE;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [BIN_W-1:0]        in_bin_index = '0;
  logic [MAG_W-1:0]        in_magnitude = '0;
  logic [FRESH_W-1:0]      in_fresh_count = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [BIN_W-1:0]        out_bin;
  logic signed [LVL_W-1:0] out_level;

  spectrum_db_peak_hold_decay #(
    .NUM_BINS(NUM_BINS_DEF)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_bin_index(in_bin_index),
    .in_magnitude(in_magnitude),
    .in_fresh_count(in_fresh_count),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_bin(out_bin),
    .out_level(out_level)
  );

  // Shadow copy of the block's state: the decay rate, the floor and the
  // held level of every bin, the last kept as plain integers for easy arithmetic.
  logic [FALL_W-1:0]       fall_rate = FALL_RESET;
  logic signed [LVL_W-1:0] scale_bottom = FLOOR_RESET;
  int                      held_db [NUM_BINS_DEF];

  // Levels still owed by the block, oldest first.
  res_t     level_q [$];
  int       err_count = 0;
  int       quiet_cycles = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  int       mode_left = 0;

  // Directed plan. Hand-computed levels appear only where they are obvious:
  // the reset floor, unit magnitude (0 dB), full scale and a positive floor.
  plan_row_t plan [PLAN_ROWS] = '{
    // Fresh count of zero right after reset reads back the cleared floor.
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd0,   32'h0000_0000, 20'd0,      1'b1, FLOOR_RESET},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd511, 32'hFFFF_FFFF, 20'd0,      1'b1, FLOOR_RESET},
    // Magnitudes of zero and one LSB both map to the floor.
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd1,   32'h0000_0000, 20'd1,      1'b1, FLOOR_RESET},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd2,   32'h0000_0001, 20'd1,      1'b1, FLOOR_RESET},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd3,   32'h0100_0000, 20'd1,      1'b1, 16'sd0},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd511, 32'hFFFF_FFFF, 20'hFFFFF,  1'b1, 16'sd12321},
    // Decay of a full-scale peak: a tiny fall, then a saturated one.
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd511, 32'h0000_0000, 20'd1,      1'b0, '0},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd511, 32'h0000_0000, 20'hFFFFF,  1'b0, '0},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd3,   32'h0080_0000, 20'd44100,  1'b0, '0},
    // Lowest floor, with junk in the unused upper data bits, so that
    // magnitudes with the leading one from bit 3 to bit 7 stay above it.
    '{1'b1, CFG_FLOOR_LEVEL,     20'hF8000, 9'd0, 32'h0,       20'd0,      1'b0, '0},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd4,   32'h0000_00FF, 20'd1,      1'b0, '0},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd5,   32'h0000_0003, 20'd1,      1'b0, '0},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd6,   32'h0000_0009, 20'd1,      1'b0, '0},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd7,   32'h0000_01FF, 20'd1,      1'b0, '0},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd4,   32'h0000_0002, 20'd7,      1'b0, '0},
    // Steepest decay rate.
    '{1'b1, CFG_FALL_PER_SAMPLE, 20'hFFFFF, 9'd0, 32'h0,       20'd0,      1'b0, '0},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd3,   32'h0001_0000, 20'd1,      1'b0, '0},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd6,   32'h0000_0000, 20'd300,    1'b0, '0},
    // No decay at all: the peak holds forever.
    '{1'b1, CFG_FALL_PER_SAMPLE, 20'h00000, 9'd0, 32'h0,       20'd0,      1'b0, '0},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd511, 32'h0000_0000, 20'hFFFFF,  1'b0, '0},
    // A positive floor pattern is taken at face value and lifts every bin that is updated.
    '{1'b1, CFG_FLOOR_LEVEL,     20'h07FFF, 9'd0, 32'h0,       20'd0,      1'b0, '0},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd8,   32'hFFFF_FFFF, 20'd1,      1'b1, 16'sd32767},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd8,   32'h0000_0000, 20'd0,      1'b0, '0},
    // A floor of zero.
    '{1'b1, CFG_FLOOR_LEVEL,     20'h00000, 9'd0, 32'h0,       20'd0,      1'b0, '0},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd9,   32'h0000_0010, 20'd3,      1'b0, '0},
    '{1'b0, CFG_FALL_PER_SAMPLE, 20'h0, 9'd9,   32'h0000_0010, 20'd3,      1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Magnitude to dB in Q8.8: log2 from the leading-one position plus the
  // next 8 bits as a linear fraction, scaled by 1541/256, floored at the
  // configured bottom of the scale.
  function automatic int mag_to_db(input logic [MAG_W-1:0] m);
    int         pos;
    logic [7:0] frac;
    int         lg;
    int         db;
    if (m < 2) begin
      return int'(scale_bottom);
    end
    pos = MAG_W - 1;
    while (pos > 0 && !m[pos]) begin
      pos--;
    end
    if (pos >= 8) begin
      frac = 8'(m >> (pos - 8));
    end else begin
      // Few bits below the leading one: left-justify them in the fraction.
      frac = 8'(m << (8 - pos));
    end
    lg = (pos - 24) * 256 + int'(frac);
    db = (lg * int'(DB_PER_LOG2)) >>> 8;
    if (db < int'(scale_bottom)) begin
      db = int'(scale_bottom);
    end
    return db;
  endfunction

  // Peak-hold update of one bin; returns the level the block reports.
  function automatic logic signed [LVL_W-1:0] hold_level(input logic [BIN_W-1:0] bin,
                                                         input logic [MAG_W-1:0] mag,
                                                         input logic [FRESH_W-1:0] fresh);
    int                 db;
    int                 cur;
    int                 drop;
    logic [FPROD_W-1:0] prod;
    if (fresh == 0) begin
      return LVL_W'(held_db[bin]);
    end
    db = mag_to_db(mag);
    cur = held_db[bin];
    if (db >= cur) begin
      cur = db;
    end else begin
      // The fall is fresh * rate / 2^16, saturated to 16 bits, and the level
      // never sinks below what is being fed in now.
      prod = fresh * fall_rate;
      drop = (prod[FPROD_W-1:16] > 65535) ? 65535 : int'(prod[FPROD_W-1:16]);
      cur = cur - drop;
      if (cur < db) begin
        cur = db;
      end
    end
    held_db[bin] = cur;
    return LVL_W'(cur);
  endfunction

  // Present one beat, possibly after an idle gap, and log the level it owes
  // once the handshake is certain. in_ready is looked at on the falling edge,
  // where it already holds the value the block sees at the next rising edge.
  task automatic send_beat(input logic [BIN_W-1:0] bin, input logic [MAG_W-1:0] mag,
                           input logic [FRESH_W-1:0] fresh, input logic typed,
                           input logic signed [LVL_W-1:0] typed_level);
    res_t want;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // Now and then a long burst gives the pipeline a stretch with no gaps.
      burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 150 : 12);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_bin_index   <= bin;
    in_magnitude   <= mag;
    in_fresh_count <= fresh;
    do @(negedge clk); while (!in_ready);
    want.bin   = bin;
    want.level = hold_level(bin, mag, fresh);
    if (typed) begin
      want.level = typed_level;
    end
    level_q.push_back(want);
    @(posedge clk);
  endtask

  // Let the block run dry before touching a register.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_FALL_PER_SAMPLE) begin
      fall_rate = data[FALL_W-1:0];
    end else begin
      scale_bottom = data[LVL_W-1:0];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: each mode lasts a random number of cycles. In the clogged mode
  // the result queue fills and in_ready drops, which stalls the sender too.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   <= rx_mode_t'($urandom_range(0, 2));
      mode_left <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_FREE: begin
        out_ready <= 1'b1;
      end
      RX_CHOPPY: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_ready <= ($urandom_range(0, 15) == 0);
      end
    endcase
  end

  // Result checker and hang watchdog. Both sample on the falling edge, where
  // every signal is settled for the rising edge that follows.
  always @(negedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (level_q.size() == 0) begin
        $display("%0t: result with nothing expected: bin %0d level %0d",
                 $time, out_bin, out_level);
        err_count++;
      end else begin
        want = level_q.pop_front();
        if (out_bin !== want.bin) begin
          $display("%0t: out_bin expected %0d got %0d", $time, want.bin, out_bin);
          err_count++;
        end
        if (out_level !== want.level) begin
          $display("%0t: level of bin %0d expected %0d got %0d",
                   $time, want.bin, want.level, out_level);
          err_count++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    logic [BIN_W-1:0]   bin;
    logic [MAG_W-1:0]   mag;
    logic [FRESH_W-1:0] fresh;
    logic [BIN_W-1:0]   hot_base;
    logic [CFG_W-1:0]   fall_val;
    logic [CFG_W-1:0]   floor_val;

    foreach (held_db[i]) begin
      held_db[i] = int'(FLOOR_RESET);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // The block clears its level memory first; in_ready rises when done.
    do @(negedge clk); while (!in_ready);
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results();
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        send_beat(plan[i].bin, plan[i].mag, plan[i].fresh, plan[i].typed,
                  plan[i].typed_level);
      end
    end

    // Random phases. The first two pin the decay rate extremes, the lowest floor and a zero
    // floor; the rest pick a mix of extremes, the reset values and arbitrary patterns.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        fall_val  = 20'hFFFFF;
        floor_val = 20'h08000;
      end else if (ph == 1) begin
        fall_val  = '0;
        floor_val = 20'hF0000;
      end else begin
        case ($urandom_range(0, 4))
          0: fall_val = '0;
          1: fall_val = 20'hFFFFF;
          2: fall_val = FALL_RESET;
          3: fall_val = CFG_W'($urandom_range(0, 20'hFFFFF));
          default: fall_val = CFG_W'($urandom_range(1, 64000));
        endcase
        case ($urandom_range(0, 4))
          0: floor_val[15:0] = 16'h8000;
          1: floor_val[15:0] = 16'h0000;
          2: floor_val[15:0] = FLOOR_RESET;
          3: floor_val[15:0] = 16'(-int'($urandom_range(1, 32768)));
          default: floor_val[15:0] = 16'($urandom);
        endcase
        floor_val[19:16] = 4'($urandom);
      end
      drain_results();
      write_reg(CFG_FALL_PER_SAMPLE, fall_val);
      write_reg(CFG_FLOOR_LEVEL, floor_val);

      // Most beats hit a handful of neighboring bins, so that peaks are
      // followed by decays and back-to-back beats of the same bin are common.
      hot_base = 9'($urandom);
      repeat (BEATS_PER_PHASE) begin
        if ($urandom_range(0, 3) == 0) begin
          bin = 9'($urandom);
        end else begin
          bin = hot_base + 9'($urandom_range(0, 7));
        end
        case ($urandom_range(0, 15))
          0: mag = $urandom_range(0, 1);
          1: mag = '1;
          default: mag = $urandom >> $urandom_range(0, 31);
        endcase
        case ($urandom_range(0, 9))
          0: fresh = '0;
          1: fresh = '1;
          2, 3: fresh = FRESH_W'($urandom_range(0, 20'hFFFFF));
          default: fresh = FRESH_W'($urandom_range(1, 4096));
        endcase
        send_beat(bin, mag, fresh, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    // Keep the clock running to catch any stray result.
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
